FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is active.
`define LHR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("line history ring: assertion failed");

// Implication form: when the condition holds, the consequence holds in the same cycle.
`define LHR_ASSERT_IMPL(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("line history ring: implication failed");

`endif

FILE: sv/lhr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lhr_pkg;

  // Default geometry of the history store
  localparam int DEPTH_DEF    = 8;
  localparam int LINE_LEN_DEF = 32;

  // Largest character count a read can report
  localparam int COUNT_MAX = 31;

  // Entries in the command queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] NUL_BYTE = 8'h00;

  // Request kinds
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_NEWER = 2'd2,
    OP_OLDER = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_char;
    logic [5:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [4:0] count;
    logic       ok;
    logic       last;
  } out_item_t;

  // Classified request as handed to the back end
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [4:0] maxc;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/lhr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lhr_front #(
  parameter int LINE_LEN = lhr_pkg::LINE_LEN_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  lhr_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  wire               cmd_ready_i,
  output lhr_pkg::cmd_t     cmd_o
);

  // Read length cap: the line holds at most LINE_LEN-1 characters
  localparam int CAP = (LINE_LEN - 1 < lhr_pkg::COUNT_MAX) ? LINE_LEN - 1
                                                             : lhr_pkg::COUNT_MAX;

  logic          vld_q;
  lhr_pkg::cmd_t cmd_q, cmd_d;
  logic [5:0]    lim_m1;

  // Classify the request and clamp the read length
  always_comb begin
    lim_m1 = (in_item_i.read_limit == 6'd0) ? 6'd0 : in_item_i.read_limit - 6'd1;
    cmd_d.op = lhr_pkg::op_e'(in_item_i.kind);
    cmd_d.ch = in_item_i.data_char;
    if (lim_m1 > 6'(CAP)) begin
      cmd_d.maxc = 5'(CAP);
    end else begin
      cmd_d.maxc = lim_m1[4:0];
    end
  end

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  // Control: one staged request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (cmd_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lhr_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lhr_cmd_queue (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_valid_i,
  output logic          push_ready_o,
  input  lhr_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  wire           pop_ready_i,
  output lhr_pkg::cmd_t pop_cmd_o
);

  localparam int PW = (lhr_pkg::QUEUE_DEPTH > 1) ? $clog2(lhr_pkg::QUEUE_DEPTH) : 1;

  lhr_pkg::cmd_t    entry_q [lhr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(lhr_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(lhr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lhr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lhr_back #(
  parameter int DEPTH    = lhr_pkg::DEPTH_DEF,
  parameter int LINE_LEN = lhr_pkg::LINE_LEN_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cmd_valid_i,
  output logic               cmd_ready_o,
  input  lhr_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output lhr_pkg::out_item_t out_item_o
);

  localparam int RW = $clog2(DEPTH);
  localparam int CW = $clog2(LINE_LEN);
  localparam int AW = RW + CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TERM = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_OLD  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  // Line store: row = slot, column = byte offset
  logic [7:0]       mem [1 << AW];
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic [DEPTH-1:0] row_valid_q, row_valid_d;

  logic [2:0]    state_q, state_d;
  logic [RW-1:0] newest_q, newest_d, view_q, view_d, prev_q, prev_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [4:0]    n_q, n_d, maxc_q, maxc_d;
  logic          ok_q, ok_d, pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  lhr_pkg::out_item_t out_q, out_d;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd, byte_rd;
  logic          out_free;
  logic [RW-1:0] newest_nxt, view_nxt, view_prv;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Rows never written read as zero
  assign byte_rd = rd_vld_q ? rd_data_q : lhr_pkg::NUL_BYTE;
  assign ra      = (state_q == S_OLD) ? {prev_q, {CW{1'b0}}} : {view_q, CW'(n_q)};

  // Ring neighbors
  assign newest_nxt = (newest_q == RW'(DEPTH - 1)) ? '0 : newest_q + RW'(1);
  assign view_nxt   = (view_q == RW'(DEPTH - 1)) ? '0 : view_q + RW'(1);
  assign view_prv   = (view_q == '0) ? RW'(DEPTH - 1) : view_q - RW'(1);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    newest_d    = newest_q;
    view_d      = view_q;
    prev_d      = prev_q;
    fill_d      = fill_q;
    n_d         = n_q;
    maxc_d      = maxc_q;
    ok_d        = ok_q;
    pend_d      = pend_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    wa          = {newest_q, fill_q};
    wd          = cmd_i.ch;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            lhr_pkg::OP_WRITE: begin
              if (cmd_i.ch != lhr_pkg::NUL_BYTE) begin
                if (fill_q < CW'(LINE_LEN - 1)) begin
                  we                    = 1'b1;
                  row_valid_d[newest_q] = 1'b1;
                  fill_d                = fill_q + CW'(1);
                  state_d               = S_TERM;
                end else begin
                  ok_d    = 1'b0;
                  state_d = S_RESP;
                end
              end else if (fill_q == '0) begin
                ok_d    = 1'b0;
                state_d = S_RESP;
              end else begin
                // line end: slot is already terminated by the last byte write
                fill_d   = '0;
                newest_d = newest_nxt;
                view_d   = newest_nxt;
                ok_d     = 1'b1;
                state_d  = S_RESP;
              end
            end
            lhr_pkg::OP_READ: begin
              n_d     = '0;
              maxc_d  = cmd_i.maxc;
              pend_d  = 1'b0;
              state_d = S_READ;
            end
            lhr_pkg::OP_NEWER: begin
              if (view_nxt != newest_q) begin
                view_d = view_nxt;
                ok_d   = 1'b1;
              end else begin
                ok_d   = 1'b0;
              end
              state_d = S_RESP;
            end
            lhr_pkg::OP_OLDER: begin
              prev_d  = view_prv;
              pend_d  = 1'b0;
              state_d = S_OLD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TERM: begin
        // keep the partial line terminated
        we      = 1'b1;
        wd      = lhr_pkg::NUL_BYTE;
        ok_d    = 1'b0;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_char: lhr_pkg::NUL_BYTE, count: 5'd0, ok: ok_q, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_READ: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else if (n_q == maxc_q || byte_rd == lhr_pkg::NUL_BYTE) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{out_char: lhr_pkg::NUL_BYTE, count: n_q, ok: 1'b0, last: 1'b1};
            state_d     = S_IDLE;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_char: byte_rd, count: 5'd0, ok: 1'b0, last: 1'b0};
          n_d         = n_q + 5'd1;
          pend_d      = 1'b0;
        end
      end
      S_OLD: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else begin
          if (prev_q != newest_q && byte_rd != lhr_pkg::NUL_BYTE) begin
            view_d = prev_q;
            ok_d   = 1'b1;
          end else begin
            ok_d   = 1'b0;
          end
          state_d = S_RESP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      newest_q    <= '0;
      view_q      <= '0;
      fill_q      <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      view_q      <= view_d;
      fill_q      <= fill_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    n_q    <= n_d;
    maxc_q <= maxc_d;
    ok_q   <= ok_d;
    out_q  <= out_d;
  end

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[ra];
    rd_vld_q  <= row_valid_q[ra[AW-1:CW]];
  end

endmodule

`default_nettype wire

FILE: sv/line_history_ring_core.sv
// Command line history ring.
// Input channel (in_valid_i / in_ready_o / in_item_i) takes one request per handshake:
// kind 0 writes a byte of the line being typed (zero ends it), kind 1 reads the viewed
// line, kinds 2 and 3 move the view one slot newer or older.
// Output channel (out_valid_o / out_ready_i / out_item_o) returns the result items;
// the item that closes a request has last set.
// A request passes the front stage, the queue, the back-end sequencer and the output
// register before its first result leaves. In the back end a stored byte goes through
// the idle, terminate and response states; any other write or a newer step goes from
// idle straight to response; an older step fetches the first byte of the older slot
// before responding; a read fetches each character before emitting it, then closes
// with the count item, its pace set by the single registered read port of the line store.
// Requests wait in the front register and a two-entry queue, so the input keeps
// accepting up to three requests while the back end works or the output stalls; a
// stalled output holds its item and the sequencer waits with it.
// Reset empties the history at once: each slot has a valid bit, and a slot never
// written reads as an empty line. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module line_history_ring_core #(
  parameter int DEPTH    = lhr_pkg::DEPTH_DEF,
  parameter int LINE_LEN = lhr_pkg::LINE_LEN_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  lhr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output lhr_pkg::out_item_t out_item_o
);

  logic          f_valid, f_ready, b_valid, b_ready;
  lhr_pkg::cmd_t f_cmd, b_cmd;

  lhr_front #(
    .LINE_LEN (LINE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  lhr_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  lhr_back #(
    .DEPTH    (DEPTH),
    .LINE_LEN (LINE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: sv/lhr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lhr_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input lhr_pkg::out_item_t out_item_i
);

  // A stalled result holds
  `LHR_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_item_i)))

  // Character items carry a real character and nothing else
  `LHR_ASSERT_IMPL(a_char_item, clk_i, rst_ni, out_valid_i && !out_item_i.last, out_item_i.out_char != 8'h00 && out_item_i.count == 5'd0 && !out_item_i.ok)

  // Closing items carry no character
  `LHR_ASSERT_IMPL(a_last_item, clk_i, rst_ni, out_valid_i && out_item_i.last, out_item_i.out_char == 8'h00)

  // A read count and a success flag never come together
  `LHR_ASSERT_IMPL(a_ok_no_count, clk_i, rst_ni, out_valid_i && out_item_i.ok, out_item_i.count == 5'd0 && out_item_i.last)

endmodule

bind line_history_ring_core lhr_checker u_lhr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire

FILE: test/tb_line_history_ring_core.sv
`timescale 1ns / 1ps

module tb_line_history_ring_core;

  localparam int DEPTH       = lhr_pkg::DEPTH_DEF;
  localparam int LINE_LEN    = lhr_pkg::LINE_LEN_DEF;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  lhr_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  lhr_pkg::out_item_t out_item_o;

  line_history_ring_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Shadow copy of the history ring
  logic [7:0] history [DEPTH][LINE_LEN];
  int         newest_slot;
  int         view_slot;
  int         fill_pos;

  lhr_pkg::out_item_t pending_results[$];
  lhr_pkg::in_item_t  req_backlog[$];
  lhr_pkg::out_item_t want_res;

  int  requests_sent;
  int  mismatch_cnt;
  int  cycle_cnt;
  int  send_gap;
  int  sink_stall;
  int  hold_reqs;
  int  hold_done;
  int  hold_left;
  bit  quiet;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expected result items for one accepted request
  function automatic void predict_history_op(input lhr_pkg::in_item_t req);
    lhr_pkg::out_item_t r;
    int        maxc;
    int        n;
    int        prev;
    r = '0;
    r.last = 1'b1;
    case (req.kind)
      lhr_pkg::OP_WRITE: begin
        if (req.data_char != lhr_pkg::NUL_BYTE) begin
          // bytes past the line capacity are dropped
          if (fill_pos < LINE_LEN - 1) begin
            history[newest_slot][fill_pos] = req.data_char;
            fill_pos++;
            history[newest_slot][fill_pos] = lhr_pkg::NUL_BYTE;
          end
        end else if (fill_pos != 0) begin
          history[newest_slot][fill_pos] = lhr_pkg::NUL_BYTE;
          fill_pos    = 0;
          newest_slot = (newest_slot + 1) % DEPTH;
          view_slot   = newest_slot;
          r.ok        = 1'b1;
        end
        pending_results.push_back(r);
      end
      lhr_pkg::OP_READ: begin
        maxc = (req.read_limit == 0) ? 0 : int'(req.read_limit) - 1;
        if (maxc > LINE_LEN - 1) maxc = LINE_LEN - 1;
        if (maxc > lhr_pkg::COUNT_MAX) maxc = lhr_pkg::COUNT_MAX;
        n = 0;
        while (n < maxc && history[view_slot][n] != lhr_pkg::NUL_BYTE) begin
          pending_results.push_back('{out_char: history[view_slot][n], count: 5'd0,
                                      ok: 1'b0, last: 1'b0});
          n++;
        end
        r.count = 5'(n);
        pending_results.push_back(r);
      end
      lhr_pkg::OP_NEWER: begin
        n = (view_slot + 1) % DEPTH;
        if (n != newest_slot) begin
          view_slot = n;
          r.ok      = 1'b1;
        end
        pending_results.push_back(r);
      end
      default: begin
        prev = (view_slot == 0) ? DEPTH - 1 : view_slot - 1;
        if (prev != newest_slot && history[prev][0] != lhr_pkg::NUL_BYTE) begin
          view_slot = prev;
          r.ok      = 1'b1;
        end
        pending_results.push_back(r);
      end
    endcase
  endfunction

  function automatic bit field_differs(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Request driver: drives requests from the backlog, predicts on each handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_history_op(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_item_i  <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted in cycles
  always @(posedge clk_i) begin
    if (hold_done < hold_reqs) begin
      hold_done++;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result sink: checks each result and paces out_ready_i
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual char %0h count %0d ok %0b last %0b",
                   $time, out_item_o.out_char, out_item_o.count, out_item_o.ok,
                   out_item_o.last);
          mismatch_cnt++;
        end else begin
          want_res = pending_results.pop_front();
          if (field_differs("out_char", want_res.out_char, out_item_o.out_char)
              | field_differs("count", 8'(want_res.count), 8'(out_item_o.count))
              | field_differs("ok", 8'(want_res.ok), 8'(out_item_o.ok))
              | field_differs("last", 8'(want_res.last), 8'(out_item_o.last)))
            mismatch_cnt++;
        end
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        sink_stall = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_req(input lhr_pkg::op_e kind, input logic [7:0] ch,
                          input logic [5:0] lim);
    lhr_pkg::in_item_t req;
    req.kind       = kind;
    req.data_char  = ch;
    req.read_limit = lim;
    while (req_backlog.size() >= 2) @(posedge clk_i);
    req_backlog.push_back(req);
    requests_sent++;
  endtask

  // Types a line of random nonzero bytes, then the terminating zero
  task automatic enter_line(input int len);
    repeat (len) send_req(lhr_pkg::OP_WRITE, 8'($urandom_range(1, 255)),
                          6'($urandom_range(0, 63)));
    send_req(lhr_pkg::OP_WRITE, lhr_pkg::NUL_BYTE, 6'($urandom_range(0, 63)));
  endtask

  task automatic test_empty_history();
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd63);
    send_req(lhr_pkg::OP_OLDER, 8'hff, 6'd0);
    send_req(lhr_pkg::OP_NEWER, 8'h00, 6'd63);
    send_req(lhr_pkg::OP_READ, 8'hff, 6'd1);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd0);
  endtask

  task automatic test_empty_line();
    send_req(lhr_pkg::OP_WRITE, lhr_pkg::NUL_BYTE, 6'd32);
  endtask

  task automatic test_line_entry();
    send_req(lhr_pkg::OP_WRITE, 8'hff, 6'd0);
    send_req(lhr_pkg::OP_WRITE, 8'h01, 6'd63);
    send_req(lhr_pkg::OP_WRITE, 8'h80, 6'd0);
    send_req(lhr_pkg::OP_WRITE, 8'h7f, 6'd63);
    send_req(lhr_pkg::OP_WRITE, lhr_pkg::NUL_BYTE, 6'd0);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd32);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd3);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd1);
  endtask

  task automatic test_view_steps();
    send_req(lhr_pkg::OP_WRITE, 8'h41, 6'd1);
    send_req(lhr_pkg::OP_WRITE, 8'h42, 6'd1);
    send_req(lhr_pkg::OP_WRITE, lhr_pkg::NUL_BYTE, 6'd1);
    // older into a stored line, then into a never-used slot
    send_req(lhr_pkg::OP_OLDER, 8'h00, 6'd2);
    send_req(lhr_pkg::OP_OLDER, 8'h00, 6'd2);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd63);
    // newer steps refused at the slot being filled
    send_req(lhr_pkg::OP_NEWER, 8'h00, 6'd2);
    send_req(lhr_pkg::OP_NEWER, 8'h00, 6'd2);
  endtask

  // Sink stalls for a long stretch while long reads pile up
  task automatic test_backpressure();
    hold_reqs++;
    enter_line(24);
    repeat (5) send_req(lhr_pkg::OP_READ, 8'($urandom), 6'd63);
  endtask

  task automatic test_random_traffic();
    int pick;
    int len;
    int line_no;
    line_no = 0;
    while (requests_sent < 440) begin
      quiet = ($urandom_range(0, 7) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 50) begin
        line_no++;
        if (line_no % 6 == 0) len = $urandom_range(31, 40);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(9, 30);
        else len = $urandom_range(1, 8);
        enter_line(len);
      end else if (pick < 68) begin
        send_req(lhr_pkg::OP_READ, 8'($urandom), 6'($urandom_range(0, 63)));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4))
          send_req(lhr_pkg::OP_NEWER, 8'($urandom), 6'($urandom_range(0, 63)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 9))
          send_req(lhr_pkg::OP_OLDER, 8'($urandom), 6'($urandom_range(0, 63)));
      end else begin
        // noise: any kind, any payload
        send_req(lhr_pkg::op_e'($urandom_range(0, 3)), 8'($urandom),
                 6'($urandom_range(0, 63)));
      end
    end
  endtask

  // Closing stretch with both sides running flat out
  task automatic test_quiet_tail();
    quiet = 1'b1;
    enter_line(6);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd63);
    repeat (3) send_req(lhr_pkg::OP_OLDER, 8'h00, 6'd5);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd5);
    repeat (3) send_req(lhr_pkg::OP_NEWER, 8'h00, 6'd5);
    send_req(lhr_pkg::OP_READ, 8'h00, 6'd63);
  endtask

  initial begin
    foreach (history[s, b]) history[s][b] = lhr_pkg::NUL_BYTE;
    newest_slot = 0;
    view_slot   = 0;
    fill_pos    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_history();
    test_empty_line();
    test_line_entry();
    test_view_steps();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();

    // wait for every expected result, then a short tail
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
